/* src/mbll_pkg.sv */
// Shared types and constants for the masked box log loss block.
package mbll_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_PROD,
      ST_ACCUM,
      ST_MEAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       first;
      logic       log_step;
      logic       product;
      logic       accum;
      logic       mean_mul;
      logic       mean_add;
      logic [1:0] mean_sel;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
   } status_type;

   localparam logic [1:0] CSR_NUM_CLASSES = 2'd0;
   localparam logic [1:0] CSR_INV_COUNT   = 2'd1;
   localparam logic [1:0] CSR_GRAD_SCALE  = 2'd2;

   localparam int          LOG_STEPS = 16;
   localparam int          SUM_W     = 48;
   localparam logic [22:0] GRAD_CAP  = 23'd6553600;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;

endpackage

/* src/masked_box_log_loss_core.sv */
// Top level of the masked box log loss block.
// Each request beat is one (pixel, class) element. The block masks the element
// when the pixel is black, when the class is outside num_classes, or when the
// label marks the pixel inside a box of that class; otherwise it adds
// -ln(1-p) to a running sum and returns the gradient min(1/(1-p),100)*grad_scale.
// On a beat with tlast the response also carries the mean loss (sum times
// inv_element_count) flagged in tuser, and the sum clears. One element is in
// work at a time: the bit-serial restoring divider runs PROB_FRAC_BITS+17 steps
// while the log unit squares its mantissa alongside, and a tlast beat adds the
// mean multiply-accumulate steps. A finished response is held in an output
// register, so the next beat's work can start only after that register has
// taken the previous result.
module masked_box_log_loss_core #(
   parameter int MAX_CLASSES    = 32,
   parameter int PROB_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   // pixel_red, pixel_green, pixel_blue, box_label, class_index, prob, zero pad
   input  logic [(((24 + MAX_CLASSES + ((MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1)
                    + PROB_FRAC_BITS + 1) + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // gradient, mean_loss
   output logic [55:0]       rsp_tdata,
   // loss_valid
   output logic              rsp_tuser
);

   localparam int CW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int PW   = PROB_FRAC_BITS + 1;
   localparam int LB0  = 24;
   localparam int CB0  = LB0 + MAX_CLASSES;
   localparam int PB0  = CB0 + CW;

   mbll_pkg::cmd_type    cmd;
   mbll_pkg::status_type status;
   logic                 req_fire;
   logic signed [31:0]   gradient;
   logic [23:0]          mean_loss;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid & req_tready;

   mbll_ctrl #(
      .PROB_FRAC_BITS(PROB_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   mbll_dp #(
      .MAX_CLASSES   (MAX_CLASSES),
      .PROB_FRAC_BITS(PROB_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pixel_red   (req_tdata[7:0]),
      .pixel_green (req_tdata[15:8]),
      .pixel_blue  (req_tdata[23:16]),
      .box_label   (req_tdata[CB0-1:LB0]),
      .class_index (req_tdata[PB0-1:CB0]),
      .prob        (req_tdata[PB0+PW-1:PB0]),
      .last        (req_tlast),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .gradient    (gradient),
      .loss_valid  (rsp_tuser),
      .mean_loss   (mean_loss)
   );

   // pack the response beat: gradient low, mean loss above
   assign rsp_tdata = {mean_loss, gradient};

endmodule

/* src/mbll_ctrl.sv */
// Sequencer for the masked box log loss datapath.
module mbll_ctrl #(
   parameter int PROB_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  mbll_pkg::status_type status,
   output logic                req_ready,
   output mbll_pkg::cmd_type    cmd
);

   localparam int QW    = PROB_FRAC_BITS + 17;
   localparam int CNT_W = $clog2(QW + 1);

   mbll_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbll_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         mbll_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_fire) state_in = mbll_pkg::ST_RUN;
         end
         mbll_pkg::ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) state_in = mbll_pkg::ST_PROD;
         end
         mbll_pkg::ST_PROD: state_in = mbll_pkg::ST_ACCUM;
         mbll_pkg::ST_ACCUM: begin
            cnt_in = '0;
            state_in = status.last ? mbll_pkg::ST_MEAN : mbll_pkg::ST_DONE;
         end
         mbll_pkg::ST_MEAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) state_in = mbll_pkg::ST_DONE;
         end
         mbll_pkg::ST_DONE: begin
            if (status.out_free) state_in = mbll_pkg::ST_IDLE;
         end
         default: state_in = mbll_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mbll_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_fire;
         end
         mbll_pkg::ST_RUN: begin
            cmd.div_step = 1'b1;
            cmd.first    = (cnt_ff == '0);
            cmd.log_step = (cnt_ff < CNT_W'(mbll_pkg::LOG_STEPS));
         end
         mbll_pkg::ST_PROD:  cmd.product = 1'b1;
         mbll_pkg::ST_ACCUM: cmd.accum = 1'b1;
         mbll_pkg::ST_MEAN: begin
            cmd.mean_mul = (cnt_ff < CNT_W'(3));
            cmd.mean_add = (cnt_ff != '0);
            cmd.mean_sel = cnt_ff[1:0];
         end
         mbll_pkg::ST_DONE:  cmd.emit = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

/* src/mbll_dp.sv */
// Datapath: divider, log unit, multipliers, loss sum and result register.
module mbll_dp #(
   parameter int MAX_CLASSES    = 32,
   parameter int PROB_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mbll_pkg::cmd_type              cmd,
   output mbll_pkg::status_type           status,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_data,
   input  logic [7:0]                    pixel_red,
   input  logic [7:0]                    pixel_green,
   input  logic [7:0]                    pixel_blue,
   input  logic [MAX_CLASSES-1:0]        box_label,
   input  logic [((MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1)-1:0] class_index,
   input  logic [PROB_FRAC_BITS:0]       prob,
   input  logic                          last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            gradient,
   output logic                          loss_valid,
   output logic [23:0]                   mean_loss
);

   localparam int F   = PROB_FRAC_BITS;
   localparam int PW  = F + 1;
   localparam int QW  = F + 17;
   localparam int RW  = F + 2;
   localparam int EW  = $clog2(F + 1);
   localparam int TW  = EW + 16;
   localparam int SW  = mbll_pkg::SUM_W;
   localparam logic [PW-1:0] ONE = PW'(1) << F;
   localparam logic [TW-1:0] T0  = TW'(F) << 16;

   // configuration
   logic [5:0]         nc_ff, nc_in;
   logic [31:0]        inv_ff, inv_in;
   logic signed [31:0] gs_ff, gs_in;
   // per item
   logic               mask_ff, mask_in;
   logic               last_ff, last_in;
   logic [PW-1:0]      q_ff, q_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [QW-1:0]      quot_ff, quot_in;
   logic [30:0]        m_ff, m_in;
   logic [EW-1:0]      e_ff, e_in;
   logic [15:0]        frac_ff, frac_in;
   logic signed [55:0] gprod_ff, gprod_in;
   logic [TW+31:0]     lmul_ff, lmul_in;
   logic signed [31:0] grad_ff, grad_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [47:0]        pp_ff, pp_in;
   logic [79:0]        acc_ff, acc_in;
   // result register
   logic               ovalid_ff, ovalid_in;
   logic signed [31:0] ograd_ff, ograd_in;
   logic               olast_ff, olast_in;
   logic [23:0]        omean_ff, omean_in;

   logic [5:0]    eff;
   logic [PW-1:0] q_new;
   logic [EW-1:0] e_new;
   logic [61:0]   sq;
   logic [RW-1:0] rem_sh;
   logic [22:0]   r_cap;
   logic [TW-1:0] lg, t_val;
   logic [TW+32:0] lround;
   logic [SW:0]   sum_tot;
   logic signed [39:0] gshift;
   logic [47:0]   mean_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff     <= 6'd1;
         inv_ff    <= '0;
         gs_ff     <= '0;
         sum_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         nc_ff     <= nc_in;
         inv_ff    <= inv_in;
         gs_ff     <= gs_in;
         sum_ff    <= sum_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff  <= mask_in;
      last_ff  <= last_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      m_ff     <= m_in;
      e_ff     <= e_in;
      frac_ff  <= frac_in;
      gprod_ff <= gprod_in;
      lmul_ff  <= lmul_in;
      grad_ff  <= grad_in;
      pp_ff    <= pp_in;
      acc_ff   <= acc_in;
      ograd_ff <= ograd_in;
      olast_ff <= olast_in;
      omean_ff <= omean_in;
   end

   always_comb begin
      nc_in  = nc_ff;
      inv_in = inv_ff;
      gs_in  = gs_ff;
      if (csr_we) begin
         case (csr_index)
            mbll_pkg::CSR_NUM_CLASSES: nc_in  = csr_data[5:0];
            mbll_pkg::CSR_INV_COUNT:   inv_in = csr_data;
            mbll_pkg::CSR_GRAD_SCALE:  gs_in  = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      eff   = (nc_ff > 6'(MAX_CLASSES)) ? 6'(MAX_CLASSES) : nc_ff;
      q_new = (prob < ONE) ? ONE - prob : PW'(1);
      e_new = '0;
      for (int i = 0; i < PW; i++) begin
         if (q_new[i]) e_new = EW'(i);
      end
      sq      = 62'(m_ff) * 62'(m_ff);
      rem_sh  = {rem_ff[RW-2:0], cmd.first};
      r_cap   = (quot_ff > QW'(mbll_pkg::GRAD_CAP)) ? mbll_pkg::GRAD_CAP : quot_ff[22:0];
      lg      = {e_ff, frac_ff};
      t_val   = (T0 > lg) ? T0 - lg : '0;
      lround  = {1'b0, lmul_ff} + (TW+33)'(64'd2147483648);
      sum_tot = {1'b0, sum_ff} + (SW+1)'(lround[TW+32:32]);
      gshift  = 40'(gprod_ff >>> 16);
      mean_hi = acc_ff[79:32];
   end

   always_comb begin
      mask_in  = mask_ff;
      last_in  = last_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      m_in     = m_ff;
      e_in     = e_ff;
      frac_in  = frac_ff;
      gprod_in = gprod_ff;
      lmul_in  = lmul_ff;
      grad_in  = grad_ff;
      sum_in   = sum_ff;
      pp_in    = pp_ff;
      acc_in   = acc_ff;
      ovalid_in = ovalid_ff & ~rsp_ready;
      ograd_in = ograd_ff;
      olast_in = olast_ff;
      omean_in = omean_ff;

      if (cmd.load) begin
         mask_in = ((pixel_red | pixel_green | pixel_blue) != 8'd0)
                   && (6'(class_index) < eff)
                   && !box_label[class_index];
         last_in = last;
         q_in    = q_new;
         rem_in  = '0;
         quot_in = '0;
         e_in    = e_new;
         frac_in = '0;
         m_in    = 31'(q_new) << (5'd30 - 5'(e_new));
      end
      // one restoring divide step: quotient of 2^(F+16) by q
      if (cmd.div_step) begin
         if (rem_sh >= RW'(q_ff)) begin
            rem_in  = rem_sh - RW'(q_ff);
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
      end
      // one squaring step of the log2 mantissa
      if (cmd.log_step) begin
         if (sq[61]) begin
            m_in    = sq[61:31];
            frac_in = {frac_ff[14:0], 1'b1};
         end else begin
            m_in    = sq[60:30];
            frac_in = {frac_ff[14:0], 1'b0};
         end
      end
      // gradient product carries the half-LSB so the later shift rounds half up
      if (cmd.product) begin
         gprod_in = 56'(gs_ff) * $signed({33'd0, r_cap}) + 56'sd32768;
         lmul_in  = (TW+32)'(t_val) * (TW+32)'(mbll_pkg::LN2_Q32);
      end
      if (cmd.accum) begin
         acc_in = '0;
         if (mask_ff) begin
            sum_in = sum_tot[SW] ? {SW{1'b1}} : sum_tot[SW-1:0];
            if (gshift > 40'sd2147483647)       grad_in = 32'sh7FFFFFFF;
            else if (gshift < -40'sd2147483648) grad_in = 32'sh80000000;
            else                                grad_in = gshift[31:0];
         end else begin
            grad_in = '0;
         end
      end
      if (cmd.mean_mul) begin
         case (cmd.mean_sel)
            2'd0:    pp_in = 48'(sum_ff[15:0]) * 48'(inv_ff);
            2'd1:    pp_in = 48'(sum_ff[31:16]) * 48'(inv_ff);
            default: pp_in = 48'(sum_ff[47:32]) * 48'(inv_ff);
         endcase
      end
      if (cmd.mean_add) begin
         case (cmd.mean_sel)
            2'd1:    acc_in = acc_ff + 80'(pp_ff);
            2'd2:    acc_in = acc_ff + (80'(pp_ff) << 16);
            default: acc_in = acc_ff + (80'(pp_ff) << 32);
         endcase
      end
      if (cmd.emit) begin
         ovalid_in = 1'b1;
         ograd_in  = grad_ff;
         olast_in  = last_ff;
         omean_in  = '0;
         if (last_ff) begin
            omean_in = (mean_hi[47:24] != '0) ? 24'hFFFFFF : mean_hi[23:0];
            sum_in   = '0;
         end
      end
   end

   assign status.out_free = ~ovalid_ff | rsp_ready;
   assign status.last     = last_ff;
   assign rsp_valid  = ovalid_ff;
   assign gradient   = ograd_ff;
   assign loss_valid = olast_ff;
   assign mean_loss  = omean_ff;

endmodule

/* bench/mbll_checker.sv */
// Scoreboard for the masked box log loss block: predicts each response and compares it.
module mbll_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] gradient;
      logic        loss_valid;
      logic [23:0] mean_loss;
   } loss_rsp_type;

   loss_rsp_type      expected_rsp_q[$];
   logic [5:0]        classes_in_use;
   logic [31:0]       inv_count;
   logic signed [31:0] grad_gain;
   logic [47:0]       running_sum;

   // -ln(q / 2^16) in Q.16, q between 1 and 2^16
   function automatic logic [63:0] neg_ln(input logic [63:0] q);
      int unsigned e;
      logic [63:0] m, frac, lg, t;
      e = 0;
      frac = 0;
      while (e < 40 && (q >> (e + 1)) != 0) e++;
      m = q << (30 - e);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      lg = (64'(e) << 16) | frac;
      t = 64'd16 << 16;
      t = (t > lg) ? t - lg : 64'd0;
      return (t * 64'(mbll_pkg::LN2_Q32) + (64'd1 << 31)) >> 32;
   endfunction

   function automatic loss_rsp_type predict_loss(input logic [79:0] d, input logic lst);
      loss_rsp_type res;
      logic [7:0]  red, green, blue;
      logic [31:0] label;
      logic [4:0]  cls;
      logic [16:0] p;
      int unsigned eff;
      logic        keep;
      logic [63:0] q, r, loss, hi, lo, prod_a, prod_b, mean;
      longint      prod, grad;
      red = d[7:0];
      green = d[15:8];
      blue = d[23:16];
      label = d[55:24];
      cls = d[60:56];
      p = d[77:61];
      eff = (classes_in_use > 32) ? 32 : classes_in_use;
      keep = ({red, green, blue} != 0) && (cls < eff) && !label[cls];
      grad = 0;
      mean = 0;
      if (keep) begin
         q = (p < 17'd65536) ? 64'd65536 - p : 64'd1;
         r = (64'd1 << 32) / q;
         if (r > 64'(mbll_pkg::GRAD_CAP)) r = 64'(mbll_pkg::GRAD_CAP);
         prod = longint'(grad_gain) * longint'(r) + 32768;
         if (prod >= 0) grad = prod >>> 16;
         else grad = -longint'((64'(-prod) + 64'd65535) >> 16);
         if (grad > 64'sd2147483647) grad = 64'sd2147483647;
         if (grad < -64'sd2147483648) grad = -64'sd2147483648;
         loss = neg_ln(q);
         if (64'hFFFF_FFFF_FFFF - running_sum < loss) running_sum = 48'hFFFF_FFFF_FFFF;
         else running_sum = running_sum + loss[47:0];
      end
      if (lst) begin
         hi = inv_count >> 16;
         lo = inv_count & 32'hFFFF;
         prod_a = running_sum * hi;
         prod_b = running_sum * lo;
         mean = (prod_a + (prod_b >> 16)) >> 16;
         if (mean > 64'hFF_FFFF) mean = 64'hFF_FFFF;
         running_sum = 0;
      end
      res.gradient = grad[31:0];
      res.loss_valid = lst;
      res.mean_loss = mean[23:0];
      return res;
   endfunction

   assign pending = expected_rsp_q.size();

   always @(posedge clock) begin
      loss_rsp_type want;
      if (reset) begin
         expected_rsp_q.delete();
         classes_in_use = 6'd1;
         inv_count = 0;
         grad_gain = 0;
         running_sum = 0;
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mbll_pkg::CSR_NUM_CLASSES: classes_in_use = csr_data[5:0];
               mbll_pkg::CSR_INV_COUNT:   inv_count = csr_data;
               mbll_pkg::CSR_GRAD_SCALE:  grad_gain = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(predict_loss(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response beat %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_tdata[31:0] !== want.gradient) begin
                  $error("gradient: expected %h, actual %h", want.gradient, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.loss_valid) begin
                  $error("loss_valid: expected %b, actual %b", want.loss_valid, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[55:32] !== want.mean_loss) begin
                  $error("mean_loss: expected %h, actual %h", want.mean_loss,
                         rsp_tdata[55:32]);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

/* bench/tb_masked_box_log_loss_core.sv */
// Stimulus and verdict for the masked box log loss block.
module tb_masked_box_log_loss_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // pixel_red, pixel_green, pixel_blue, box_label, class_index, prob, zero pad
   logic [79:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // gradient, mean_loss
   logic [55:0] rsp_tdata;
   // loss_valid
   logic        rsp_tuser;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   bit rsp_jitter = 1'b1;     // random stalls on the response side
   bit req_jitter = 1'b1;     // random gaps on the request side
   int hold_off = 0;          // cycles the receiver refuses all beats

   always #2 clock = ~clock;

   masked_box_log_loss_core u_top (.*);

   mbll_checker u_checker (.*);

   // Response side: stall at random, or hold off entirely on request.
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(rsp_jitter && $urandom_range(99) < 6);
      end
   end

   // Watchdog: count cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("masked_box_log_loss_core regression: fail");
         $finish;
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offer one element; hold it until the block takes it.
   task automatic send_element(input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue, input logic [31:0] label,
                               input logic [4:0] cls, input logic [16:0] p,
                               input logic lst);
      while (req_jitter && $urandom_range(99) < 6) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, p, cls, label, blue, green, red};
      req_tlast = lst;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Wait for every response, then let the block go fully idle.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [5:0] ncls, input logic [31:0] inv,
                            input logic [31:0] gain);
      drain();
      write_csr(mbll_pkg::CSR_NUM_CLASSES, {26'd0, ncls});
      write_csr(mbll_pkg::CSR_INV_COUNT, inv);
      write_csr(mbll_pkg::CSR_GRAD_SCALE, gain);
   endtask

   function automatic logic [16:0] pick_prob();
      case ($urandom_range(9))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'd65535;
         3: return 17'($urandom_range(131071, 65537));
         4: return 17'($urandom_range(65535, 60000));
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   task automatic random_element();
      logic [7:0] red, green, blue;
      red = $urandom;
      green = $urandom;
      blue = $urandom;
      // black pixels now and then to exercise the mask
      if ($urandom_range(7) == 0) {red, green, blue} = '0;
      send_element(red, green, blue, ($urandom_range(1) != 0) ? $urandom : 32'd0,
                   5'($urandom), pick_prob(), $urandom_range(19) == 0);
   endtask

   initial begin
      logic [5:0]  ncls_set[6] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd7, 6'd17};
      logic [31:0] inv_set[6]  = '{32'hFFFF_FFFF, 32'd0, 32'h0100_0000, 32'h8000_0000,
                                   32'h0000_0001, 32'h0004_0000};
      logic [31:0] gain_set[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                   32'hFFFF_0000, 32'd0, 32'd1};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, masking rules, probability at and above one.
      configure(6'd4, 32'h1000_0000, 32'h0001_0000);
      send_element(8'd0, 8'd0, 8'd0, 32'd0, 5'd0, 17'd1000, 1'b0);          // black
      send_element(8'hFF, 8'hFF, 8'hFF, 32'd0, 5'd0, 17'd0, 1'b0);
      send_element(8'd1, 8'd0, 8'd0, 32'd0, 5'd3, 17'd65535, 1'b0);
      send_element(8'd0, 8'd1, 8'd0, 32'd0, 5'd1, 17'd65536, 1'b0);          // p = 1
      send_element(8'd0, 8'd0, 8'd1, 32'd0, 5'd2, 17'h1FFFF, 1'b0);          // p > 1
      send_element(8'h80, 8'h80, 8'h80, 32'hFFFF_FFFF, 5'd1, 17'd5, 1'b0);   // in box
      send_element(8'h7F, 8'h01, 8'h80, 32'hFFFF_FFF7, 5'd3, 17'd32768, 1'b0);
      send_element(8'h55, 8'hAA, 8'h0F, 32'd0, 5'd4, 17'd100, 1'b0);         // class out
      send_element(8'hAA, 8'h55, 8'hF0, 32'd0, 5'd31, 17'd100, 1'b1);
      send_element(8'd9, 8'd9, 8'd9, 32'd0, 5'd0, 17'd0, 1'b1);              // sum cleared
      send_element(8'd0, 8'd0, 8'd0, 32'd0, 5'd0, 17'd0, 1'b1);              // empty mean
      configure(6'd32, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_element(8'd3, 8'd3, 8'd3, 32'h7FFF_FFFF, 5'd31, 17'd65536, 1'b0);
      send_element(8'd3, 8'd3, 8'd3, 32'h5555_5555, 5'd1, 17'd65000, 1'b0);
      send_element(8'd3, 8'd3, 8'd3, 32'hAAAA_AAAA, 5'd0, 17'd1, 1'b0);
      repeat (6) send_element(8'd2, 8'd2, 8'd2, 32'd0, 5'd30, 17'd65536, 1'b0);
      send_element(8'd3, 8'd3, 8'd3, 32'd0, 5'd16, 17'd2, 1'b1);             // gradient saturates

      // Random phases, one register setting each.
      for (int ph = 0; ph < 6; ph++) begin
         configure(ncls_set[ph], ph == 5 ? $urandom : inv_set[ph],
                   ph == 4 ? $urandom : gain_set[ph]);
         rsp_jitter = (ph != 2);
         req_jitter = (ph != 2);
         for (int n = 0; n < 100; n++) begin
            if (ph == 1 && n == 20) hold_off = 400;   // fill the block and stall input
            if (ph == 3 && n == 50) drain();          // sender pauses until all is back
            random_element();
         end
      end

      drain();
      if (fail_count == 0)
         $display("masked_box_log_loss_core regression: pass");
      else
         $display("masked_box_log_loss_core regression: fail");
      $finish;
   end

endmodule
